### hw/rtl/sab_pkg.sv
// Shared types and constants for the scaled alpha sprite blitter.
// Used by every module under hw/rtl; depends on nothing.
`timescale 1ns / 1ps

package sab_pkg;

	localparam int COORD_BITS = 12;           // pixel_x / pixel_y width
	localparam int IDX_W      = 12;           // texel_index width
	localparam int CHAN_W     = 8;
	localparam int COLOR_W    = 3 * CHAN_W;   // 0xRRGGBB
	localparam int TEXEL_W    = 4 * CHAN_W;   // 0xRRGGBBAA
	localparam int DCOLOR_W   = 32;
	localparam int REG_W      = 13;
	localparam int FRAC_BITS  = 16;
	localparam int STEP_W     = REG_W + FRAC_BITS;     // quotient of (size << 16) / size
	localparam int MUL_W      = REG_W + STEP_W;        // offset * step
	localparam int ADDR_SUM_W = 2 * REG_W + 1;         // row * width + col
	localparam int NUM_REGS   = 8;
	localparam int REG_IDX_W  = 3;
	localparam int PADDR_W    = REG_IDX_W + 2;
	localparam int PDATA_W    = 32;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W     = 2;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_DEST_LEFT      = 3'd0,
		REG_DEST_TOP       = 3'd1,
		REG_DEST_WIDTH     = 3'd2,
		REG_DEST_HEIGHT    = 3'd3,
		REG_SPRITE_WIDTH   = 3'd4,
		REG_SPRITE_HEIGHT  = 3'd5,
		REG_SURFACE_WIDTH  = 3'd6,
		REG_SURFACE_HEIGHT = 3'd7
	} reg_idx_t;

	typedef enum logic [1:0] {
		ITEM_SKIP  = 2'd0,   // answers with write_enable 0
		ITEM_LOAD  = 2'd1,   // texel write into the sprite store
		ITEM_PIXEL = 2'd2    // pixel inside the clipped rectangle
	} item_kind_t;

	typedef enum logic {
		ACT_LOAD  = 1'b0,
		ACT_PIXEL = 1'b1
	} action_t;

	typedef struct packed {
		logic                  action;
		logic [IDX_W-1:0]      texel_index;
		logic [CHAN_W-1:0]     texel_red;
		logic [CHAN_W-1:0]     texel_green;
		logic [CHAN_W-1:0]     texel_blue;
		logic [CHAN_W-1:0]     texel_alpha;
		logic [COORD_BITS-1:0] pixel_x;
		logic [COORD_BITS-1:0] pixel_y;
		logic [DCOLOR_W-1:0]   dest_color;
	} blit_req_t;

	typedef struct packed {
		logic               write_enable;
		logic [COLOR_W-1:0] out_color;
	} blit_res_t;

	typedef struct packed {
		logic signed [REG_W-1:0] dest_left;
		logic signed [REG_W-1:0] dest_top;
		logic [REG_W-1:0]        dest_width;
		logic [REG_W-1:0]        dest_height;
		logic [REG_W-1:0]        sprite_width;
		logic [REG_W-1:0]        sprite_height;
		logic [REG_W-1:0]        surface_width;
		logic [REG_W-1:0]        surface_height;
		logic [STEP_W-1:0]       step_x;
		logic [STEP_W-1:0]       step_y;
	} cfg_t;

	typedef struct packed {
		item_kind_t         kind;
		logic [REG_W-1:0]   off_x;
		logic [REG_W-1:0]   off_y;
		logic [COLOR_W-1:0] color;
		logic [IDX_W-1:0]   texel_index;
		logic [TEXEL_W-1:0] texel;
	} q_item_t;

endpackage

### hw/rtl/sab_stepdiv.sv
// Restoring divider for the 13.16 scale step: (num << 16) / den, one bit a cycle.
// Depends on sab_pkg.
`timescale 1ns / 1ps

module sab_stepdiv (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [sab_pkg::REG_W-1:0]     num,
	input  logic [sab_pkg::REG_W-1:0]     den,
	output logic [sab_pkg::STEP_W-1:0]    quo,
	output logic                          busy
);

	localparam int W  = sab_pkg::STEP_W;
	localparam int RW = sab_pkg::REG_W;
	localparam int CW = $clog2(W + 1);

	logic [W-1:0]  work_q;   // dividend shifts out the top, quotient in the bottom
	logic [RW-1:0] rem_q;
	logic [RW-1:0] den_q;
	logic [CW-1:0] count_q;
	logic          run_q;

	logic [RW:0]   rem_sh;
	logic          ge;

	assign rem_sh = {rem_q, work_q[W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_q  <= '0;
			rem_q   <= '0;
			den_q   <= '0;
			count_q <= '0;
			run_q   <= 1'b0;
		end else if (start) begin
			work_q  <= {num, {sab_pkg::FRAC_BITS{1'b0}}};
			rem_q   <= '0;
			den_q   <= den;
			count_q <= CW'(W);
			run_q   <= 1'b1;
		end else if (run_q) begin
			rem_q   <= ge ? RW'(rem_sh - {1'b0, den_q}) : rem_sh[RW-1:0];
			work_q  <= {work_q[W-2:0], ge};
			count_q <= count_q - CW'(1);
			if (count_q == CW'(1)) begin
				run_q <= 1'b0;
			end
		end
	end

	// zero divisor gives a zero step
	assign quo  = (den_q == '0) ? '0 : work_q;
	assign busy = run_q;

endmodule

### hw/rtl/sab_front.sv
// Front end: request handshake and classification (load, clipped pixel, skip).
// Depends on sab_pkg.
`timescale 1ns / 1ps

module sab_front #(
	parameter int SPRITE_DEPTH = 4096
) (
	input  sab_pkg::blit_req_t req_data,
	input  logic               req_valid,
	output logic               req_ready,
	input  sab_pkg::cfg_t      cfg,
	input  logic               step_busy,
	input  logic               q_full,
	output logic               push,
	output sab_pkg::q_item_t   item
);

	localparam int RW = sab_pkg::REG_W;
	localparam int LW = sab_pkg::IDX_W + 5;

	logic signed [RW+1:0] px, py, left, top, right, bottom, dx, dy;
	logic                 in_x, in_y, sizes_ok, load_ok;

	always_comb begin
		px     = signed'({3'b0, req_data.pixel_x});
		py     = signed'({3'b0, req_data.pixel_y});
		left   = {{2{cfg.dest_left[RW-1]}}, cfg.dest_left};
		top    = {{2{cfg.dest_top[RW-1]}}, cfg.dest_top};
		right  = left + signed'({2'b0, cfg.dest_width});
		bottom = top + signed'({2'b0, cfg.dest_height});
		dx     = px - left;
		dy     = py - top;

		in_x = (px >= left) && (px < right) && ({1'b0, req_data.pixel_x} < cfg.surface_width);
		in_y = (py >= top) && (py < bottom) && ({1'b0, req_data.pixel_y} < cfg.surface_height);
		sizes_ok = (cfg.dest_width != '0) && (cfg.dest_height != '0) &&
		           (cfg.sprite_width != '0) && (cfg.sprite_height != '0);
		load_ok  = {5'b0, req_data.texel_index} < LW'(SPRITE_DEPTH);

		item.kind = sab_pkg::ITEM_SKIP;
		if (req_data.action == sab_pkg::ACT_LOAD) begin
			if (load_ok) begin
				item.kind = sab_pkg::ITEM_LOAD;
			end
		end else if (sizes_ok && in_x && in_y) begin
			item.kind = sab_pkg::ITEM_PIXEL;
		end
		// inside the rectangle the offsets are below the 13-bit size
		item.off_x       = dx[RW-1:0];
		item.off_y       = dy[RW-1:0];
		item.color       = req_data.dest_color[sab_pkg::COLOR_W-1:0];
		item.texel_index = req_data.texel_index;
		item.texel       = {req_data.texel_red, req_data.texel_green,
		                    req_data.texel_blue, req_data.texel_alpha};
	end

	assign req_ready = !step_busy && !q_full;
	assign push      = req_valid && req_ready;

endmodule

### hw/rtl/sab_queue.sv
// Small FIFO between front and back ends.
// Depends on sab_pkg.
`timescale 1ns / 1ps

module sab_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sab_pkg::q_item_t din,
	output logic             full,
	input  logic             pop,
	output sab_pkg::q_item_t dout,
	output logic             not_empty
);

	localparam int PW = sab_pkg::QPTR_W;
	localparam int CW = PW + 1;

	sab_pkg::q_item_t slot_q [sab_pkg::QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	assign dout      = slot_q[rd_ptr_q];
	assign full      = count_q == CW'(sab_pkg::QUEUE_DEPTH);
	assign not_empty = count_q != '0;

endmodule

### hw/rtl/sab_back.sv
// Back end: scale sampling, sprite store, alpha blend and the result register.
// Depends on sab_pkg.
`timescale 1ns / 1ps

module sab_back #(
	parameter int SPRITE_DEPTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sab_pkg::cfg_t      cfg,
	input  sab_pkg::q_item_t   head,
	input  logic               head_valid,
	output logic               pop,
	output logic               res_valid,
	input  logic               res_ready,
	output sab_pkg::blit_res_t res_data
);

	localparam int RW  = sab_pkg::REG_W;
	localparam int MW  = sab_pkg::MUL_W;
	localparam int FB  = sab_pkg::FRAC_BITS;
	localparam int AW  = sab_pkg::ADDR_SUM_W;
	localparam int CH  = sab_pkg::CHAN_W;
	localparam int SW  = 2 * CH;
	localparam int TW  = sab_pkg::TEXEL_W;
	localparam int CLW = sab_pkg::COLOR_W;
	localparam int MEM_AW = (SPRITE_DEPTH > 1) ? $clog2(SPRITE_DEPTH) : 1;

	function automatic logic [CH-1:0] div255(input logic [SW-1:0] x);
		logic [SW-1:0] t;
		t = x + {{CH{1'b0}}, x[SW-1:CH]} + SW'(1);
		return t[SW-1:CH];
	endfunction

	logic en;

	// stage 1: offset times step
	logic                    v_s1;
	sab_pkg::item_kind_t     kind_s1;
	logic [MW-1:0]           fx_s1, fy_s1;
	logic [CLW-1:0]          color_s1;
	logic [sab_pkg::IDX_W-1:0] idx_s1;
	logic [TW-1:0]           texel_s1;
	// stage 2: clamped column and row
	logic                    v_s2;
	sab_pkg::item_kind_t     kind_s2;
	logic [RW-1:0]           col_s2, row_s2;
	logic [CLW-1:0]          color_s2;
	logic [sab_pkg::IDX_W-1:0] idx_s2;
	logic [TW-1:0]           texel_s2;
	// stage 3: linear address
	logic                    v_s3;
	sab_pkg::item_kind_t     kind_s3;
	logic [AW-1:0]           addr_s3;
	logic [CLW-1:0]          color_s3;
	logic [sab_pkg::IDX_W-1:0] idx_s3;
	logic [TW-1:0]           texel_s3;
	// stage 4: store access
	logic                    v_s4, draw_s4;
	logic [TW-1:0]           rd_s4;
	logic [CLW-1:0]          color_s4;
	// stage 5: blend sums
	logic                    v_s5, draw_s5;
	logic [SW-1:0]           sum_r_s5, sum_g_s5, sum_b_s5;
	// result
	logic                    res_valid_q;
	sab_pkg::blit_res_t      res_q;

	logic [TW-1:0]           mem [SPRITE_DEPTH];

	logic [MW-1:0]           lim_x, lim_y;
	logic [2*RW-1:0]         row_prod;
	logic [AW-1:0]           addr_sum;
	logic                    in_store;
	logic [CH-1:0]           alpha, nalpha;

	assign en  = !res_valid_q || res_ready;
	assign pop = en && head_valid;

	always_comb begin
		lim_x    = {{RW{1'b0}}, cfg.sprite_width, {FB{1'b0}}};
		lim_y    = {{RW{1'b0}}, cfg.sprite_height, {FB{1'b0}}};
		row_prod = row_s2 * cfg.sprite_width;
		addr_sum = {1'b0, row_prod} + {{(AW - RW){1'b0}}, col_s2};
		in_store = addr_s3 < AW'(SPRITE_DEPTH);
		alpha    = rd_s4[CH-1:0];
		nalpha   = ~alpha;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1  <= head.kind;
			fx_s1    <= MW'(head.off_x) * MW'(cfg.step_x);
			fy_s1    <= MW'(head.off_y) * MW'(cfg.step_y);
			color_s1 <= head.color;
			idx_s1   <= head.texel_index;
			texel_s1 <= head.texel;

			kind_s2  <= kind_s1;
			col_s2   <= (fx_s1 >= lim_x) ? cfg.sprite_width - RW'(1) : fx_s1[FB +: RW];
			row_s2   <= (fy_s1 >= lim_y) ? cfg.sprite_height - RW'(1) : fy_s1[FB +: RW];
			color_s2 <= color_s1;
			idx_s2   <= idx_s1;
			texel_s2 <= texel_s1;

			kind_s3  <= kind_s2;
			addr_s3  <= addr_sum;
			color_s3 <= color_s2;
			idx_s3   <= idx_s2;
			texel_s3 <= texel_s2;

			draw_s4  <= (kind_s3 == sab_pkg::ITEM_PIXEL) && in_store;
			color_s4 <= color_s3;

			draw_s5  <= draw_s4 && (alpha != '0);
			sum_r_s5 <= rd_s4[TW-1 -: CH] * alpha + color_s4[CLW-1 -: CH] * nalpha;
			sum_g_s5 <= rd_s4[TW-CH-1 -: CH] * alpha + color_s4[2*CH-1 -: CH] * nalpha;
			sum_b_s5 <= rd_s4[TW-2*CH-1 -: CH] * alpha + color_s4[CH-1:0] * nalpha;

			res_q.write_enable <= draw_s5;
			res_q.out_color    <= draw_s5 ?
				{div255(sum_r_s5), div255(sum_g_s5), div255(sum_b_s5)} : '0;
		end
	end

	// sprite store: one write port for loads, one registered read for pixels
	always_ff @(posedge clk) begin
		if (en) begin
			if (v_s3 && kind_s3 == sab_pkg::ITEM_LOAD) begin
				mem[MEM_AW'(idx_s3)] <= texel_s3;
			end
			rd_s4 <= mem[addr_s3[MEM_AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			res_valid_q <= 1'b0;
		end else if (en) begin
			v_s1        <= head_valid;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			res_valid_q <= v_s5;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

endmodule

### hw/rtl/scaled_alpha_sprite_blitter_top.sv
// Top level of the scaled alpha sprite blitter: APB registers, step dividers,
// front end, queue and back end. Depends on sab_pkg and all sab_* modules.
`timescale 1ns / 1ps

// Channel   Direction  Handshake               Payload
// request   in         req_valid / req_ready   req_data  (sab_pkg::blit_req_t)
// result    out        res_valid / res_ready   res_data  (sab_pkg::blit_res_t)
// config    in         APB psel/penable/pready paddr, pwdata, prdata (8 regs at 4*i)
//
// One request per clock while res_ready is high and no step divider is busy;
// every request gives exactly one result. A request passes through the queue,
// offset*step multiply, clamp, address multiply-add, store read, blend sums and
// the result register. A register write restarts the two step dividers, and
// req_ready stays low until both have finished. Reset clears registers, steps,
// queue and pipeline valid flags; the sprite store has no clearing pass and
// must be loaded before it is drawn. A stalled result freezes the back pipeline;
// the 4-entry queue then fills and req_ready drops.

module scaled_alpha_sprite_blitter_top #(
	parameter int SPRITE_DEPTH = 4096
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [sab_pkg::PADDR_W-1:0]    paddr,
	input  logic [sab_pkg::PDATA_W-1:0]    pwdata,
	output logic [sab_pkg::PDATA_W-1:0]    prdata,
	output logic                           pready,
	// request channel
	input  logic                           req_valid,
	output logic                           req_ready,
	input  sab_pkg::blit_req_t             req_data,
	// result channel
	output logic                           res_valid,
	input  logic                           res_ready,
	output sab_pkg::blit_res_t             res_data
);

	localparam int RW = sab_pkg::REG_W;

	logic [RW-1:0] regs_q [sab_pkg::NUM_REGS];
	logic          cfg_wr;
	logic          start_q;
	logic [sab_pkg::REG_IDX_W-1:0] reg_sel;

	logic [sab_pkg::STEP_W-1:0] step_x, step_y;
	logic          busy_x, busy_y, step_busy;

	sab_pkg::cfg_t    cfg;
	sab_pkg::q_item_t front_item, head;
	logic             push, q_full, pop, head_valid;

	// APB: zero wait states, writes land on the access phase
	assign pready  = 1'b1;
	assign reg_sel = paddr[sab_pkg::PADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = {{(sab_pkg::PDATA_W - RW){1'b0}}, regs_q[reg_sel]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sab_pkg::NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
			start_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				regs_q[reg_sel] <= pwdata[RW-1:0];
			end
			// dividers start the cycle after the write, on the updated registers
			start_q <= cfg_wr;
		end
	end

	sab_stepdiv u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.num    (regs_q[sab_pkg::REG_SPRITE_WIDTH]),
		.den    (regs_q[sab_pkg::REG_DEST_WIDTH]),
		.quo    (step_x),
		.busy   (busy_x)
	);

	sab_stepdiv u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.num    (regs_q[sab_pkg::REG_SPRITE_HEIGHT]),
		.den    (regs_q[sab_pkg::REG_DEST_HEIGHT]),
		.quo    (step_y),
		.busy   (busy_y)
	);

	assign step_busy = start_q || busy_x || busy_y;

	always_comb begin
		cfg.dest_left      = signed'(regs_q[sab_pkg::REG_DEST_LEFT]);
		cfg.dest_top       = signed'(regs_q[sab_pkg::REG_DEST_TOP]);
		cfg.dest_width     = regs_q[sab_pkg::REG_DEST_WIDTH];
		cfg.dest_height    = regs_q[sab_pkg::REG_DEST_HEIGHT];
		cfg.sprite_width   = regs_q[sab_pkg::REG_SPRITE_WIDTH];
		cfg.sprite_height  = regs_q[sab_pkg::REG_SPRITE_HEIGHT];
		cfg.surface_width  = regs_q[sab_pkg::REG_SURFACE_WIDTH];
		cfg.surface_height = regs_q[sab_pkg::REG_SURFACE_HEIGHT];
		cfg.step_x         = step_x;
		cfg.step_y         = step_y;
	end

	// front end: clip test and item classification
	sab_front #(
		.SPRITE_DEPTH (SPRITE_DEPTH)
	) u_front (
		.req_data  (req_data),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.cfg       (cfg),
		.step_busy (step_busy),
		.q_full    (q_full),
		.push      (push),
		.item      (front_item)
	);

	// decouples the request side from result stalls
	sab_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.din       (front_item),
		.full      (q_full),
		.pop       (pop),
		.dout      (head),
		.not_empty (head_valid)
	);

	// back end: sampling, sprite store, blend, result register
	sab_back #(
		.SPRITE_DEPTH (SPRITE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data)
	);

endmodule

### tb/sab_blit_checker.sv
// Checker for the scaled alpha sprite blitter: follows register writes and requests,
// predicts each result and compares it with what the block returns. Depends on sab_pkg.
`timescale 1ns / 1ps

module sab_blit_checker
	import sab_pkg::*;
#(
	parameter int SPRITE_DEPTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic               pready,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               req_valid,
	input  logic               req_ready,
	input  blit_req_t          req_data,
	input  logic               res_valid,
	input  logic               res_ready,
	input  blit_res_t          res_data,
	output int                 mismatches,
	output int                 pending
);

	logic [REG_W-1:0]   blit_regs [NUM_REGS];
	logic [31:0]        step_x;
	logic [31:0]        step_y;
	logic [TEXEL_W-1:0] sprite_texels [SPRITE_DEPTH];
	blit_res_t          pending_writes [$];
	int                 bad_cnt;

	// 16.16 step: (source size << 16) / destination size, zero for an empty destination
	function automatic logic [31:0] scale_step(logic [REG_W-1:0] src, logic [REG_W-1:0] dst);
		logic [47:0] num;
		num = 48'(src) << FRAC_BITS;
		if (dst == '0)
			return '0;
		return 32'(num / 48'(dst));
	endfunction

	// nearest texel along one axis, clamped to the last one
	function automatic logic [63:0] nearest_texel(logic [63:0] offset, logic [31:0] step,
			logic [REG_W-1:0] size);
		logic [63:0] f;
		logic [63:0] lim;
		f = offset * 64'(step);
		lim = 64'(size) << FRAC_BITS;
		if (f >= lim)
			f = lim - 64'd1;
		return f >> FRAC_BITS;
	endfunction

	function automatic logic [CHAN_W-1:0] mix_chan(logic [CHAN_W-1:0] s, logic [CHAN_W-1:0] d,
			logic [CHAN_W-1:0] a);
		logic [31:0] acc;
		acc = 32'(s) * 32'(a) + 32'(d) * (32'd255 - 32'(a));
		return CHAN_W'(acc / 32'd255);
	endfunction

	function automatic blit_res_t blit_pixel(blit_req_t r);
		blit_res_t          res;
		longint             left_x;
		longint             top_y;
		longint             px;
		longint             py;
		longint             dw;
		longint             dh;
		logic [REG_W-1:0]   sw;
		logic [REG_W-1:0]   sh;
		logic [63:0]        col;
		logic [63:0]        row;
		logic [63:0]        addr;
		logic [TEXEL_W-1:0] tx;
		logic [CHAN_W-1:0]  a;
		res = '0;
		left_x = longint'($signed(blit_regs[REG_DEST_LEFT]));
		top_y  = longint'($signed(blit_regs[REG_DEST_TOP]));
		dw = longint'(blit_regs[REG_DEST_WIDTH]);
		dh = longint'(blit_regs[REG_DEST_HEIGHT]);
		sw = blit_regs[REG_SPRITE_WIDTH];
		sh = blit_regs[REG_SPRITE_HEIGHT];
		px = longint'(r.pixel_x);
		py = longint'(r.pixel_y);
		if (dw == 0 || dh == 0 || sw == '0 || sh == '0)
			return res;
		if (px < left_x || px >= left_x + dw ||
				px >= longint'(blit_regs[REG_SURFACE_WIDTH]))
			return res;
		if (py < top_y || py >= top_y + dh ||
				py >= longint'(blit_regs[REG_SURFACE_HEIGHT]))
			return res;
		col = nearest_texel(64'(px - left_x), step_x, sw);
		row = nearest_texel(64'(py - top_y), step_y, sh);
		addr = row * 64'(sw) + col;
		// samples past the store are transparent
		if (addr >= 64'(SPRITE_DEPTH))
			return res;
		tx = sprite_texels[addr];
		a = tx[CHAN_W-1:0];
		if (a == '0)
			return res;
		res.write_enable = 1'b1;
		if (a == '1)
			res.out_color = tx[TEXEL_W-1:CHAN_W];
		else
			res.out_color = {mix_chan(tx[31:24], r.dest_color[23:16], a),
				mix_chan(tx[23:16], r.dest_color[15:8], a),
				mix_chan(tx[15:8], r.dest_color[7:0], a)};
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		blit_res_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++)
				blit_regs[i] = '0;
			step_x = '0;
			step_y = '0;
			pending_writes.delete();
			bad_cnt = 0;
			mismatches <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				blit_regs[paddr[PADDR_W-1:2]] = pwdata[REG_W-1:0];
				step_x = scale_step(blit_regs[REG_SPRITE_WIDTH], blit_regs[REG_DEST_WIDTH]);
				step_y = scale_step(blit_regs[REG_SPRITE_HEIGHT], blit_regs[REG_DEST_HEIGHT]);
			end
			if (req_valid && req_ready) begin
				if (req_data.action == ACT_LOAD) begin
					if (req_data.texel_index < SPRITE_DEPTH)
						sprite_texels[req_data.texel_index] = {req_data.texel_red,
							req_data.texel_green, req_data.texel_blue, req_data.texel_alpha};
					pending_writes.push_back('0);
				end else begin
					pending_writes.push_back(blit_pixel(req_data));
				end
			end
			if (res_valid && res_ready) begin
				if (pending_writes.size() == 0) begin
					bad_cnt++;
					if (bad_cnt <= 10)
						$display("%0t: result with no request outstanding: we=%0b color=%06h",
							$realtime, res_data.write_enable, res_data.out_color);
				end else begin
					want = pending_writes.pop_front();
					if (res_data.write_enable !== want.write_enable ||
							res_data.out_color !== want.out_color) begin
						bad_cnt++;
						if (bad_cnt <= 10)
							$display("%0t: mismatch: expected we=%0b color=%06h, got we=%0b color=%06h",
								$realtime, want.write_enable, want.out_color,
								res_data.write_enable, res_data.out_color);
					end
				end
			end
			mismatches <= bad_cnt;
			pending <= pending_writes.size();
		end
	end

endmodule

### tb/tb_top.sv
// Top of the blitter testbench: clock, reset, request and register stimulus, watchdog
// and verdict. Depends on sab_pkg, scaled_alpha_sprite_blitter_top and sab_blit_checker.
`timescale 1ns / 1ps

module tb_top;
	import sab_pkg::*;

	localparam int SPRITE_DEPTH     = 4096;
	localparam int WATCHDOG_LIMIT   = 4000;  // idle cycles; longest legal gap is the hold below
	localparam int HOLD_CYCLES      = 400;   // result side held off to back the block up
	localparam int NUM_PHASES       = 14;
	localparam int ITEMS_PER_PHASE  = 120;
	localparam int DRAIN_CYCLES     = 20;    // a few times the request-to-result latency

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               psel      = 1'b0;
	logic               penable   = 1'b0;
	logic               pwrite    = 1'b0;
	logic [PADDR_W-1:0] paddr     = '0;
	logic [PDATA_W-1:0] pwdata    = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               req_valid = 1'b0;
	logic               req_ready;
	blit_req_t          req_data  = '0;
	logic               res_valid;
	logic               res_ready = 1'b0;
	blit_res_t          res_data;
	int                 mismatches;
	int                 pending;

	logic calm        = 1'b0;  // no idling on either side while set
	int   hold_asked  = 0;     // holds requested by the stimulus
	int   hold_served = 0;     // holds carried out by the result sink
	bit   loaded [SPRITE_DEPTH];  // texels written since reset; unwritten ones are never sampled
	int   idle_cycles = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	scaled_alpha_sprite_blitter_top #(
		.SPRITE_DEPTH(SPRITE_DEPTH)
	) u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	sab_blit_checker #(
		.SPRITE_DEPTH(SPRITE_DEPTH)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_data   (req_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_data   (res_data),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// Watchdog: any accepted request, result or register access counts as progress.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (res_valid && res_ready) || (psel && penable && pready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// Result sink: random back-pressure, plus long holds asked for by the stimulus so
	// the queue fills and req_ready drops while requests keep coming.
	initial begin : result_sink
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_asked != hold_served) begin
				hold_served = hold_served + 1;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			res_ready <= calm || ($urandom_range(0, 99) >= 29);
		end
	end

	function automatic blit_req_t random_bits();
		logic [127:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom};
		return raw[$bits(blit_req_t)-1:0];
	endfunction

	function automatic blit_req_t texel_load(input int idx);
		blit_req_t r;
		r = random_bits();
		r.action = ACT_LOAD;
		r.texel_index = IDX_W'(idx);
		// fully transparent and opaque texels take their own paths
		case ($urandom_range(0, 3))
			0: r.texel_alpha = '0;
			1: r.texel_alpha = '1;
			default: ;
		endcase
		return r;
	endfunction

	// Mostly the rectangle edges and the span around it, so clipping gets hit.
	function automatic logic [COORD_BITS-1:0] near_coord(input int base, input int span);
		int v;
		case ($urandom_range(0, 3))
			0: v = base;
			1: v = base + span - 1;
			default: v = base + int'($urandom_range(0, span + 3)) - 2;
		endcase
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return COORD_BITS'(v);
	endfunction

	function automatic blit_req_t pixel_near(input int left_x, input int top_y,
			input int dw, input int dh);
		blit_req_t r;
		r = random_bits();
		r.action = ACT_PIXEL;
		if ($urandom_range(0, 7) != 0) begin
			r.pixel_x = near_coord(left_x, dw);
			r.pixel_y = near_coord(top_y, dh);
		end
		return r;
	endfunction

	// Store index a pixel samples under the given setup, or -1 when it writes nothing.
	function automatic int sampled_texel(input blit_req_t r, input int left_x, input int top_y,
			input int dw, input int dh, input int sw, input int sh, input int surf_w,
			input int surf_h);
		longint off_x;
		longint off_y;
		longint fx;
		longint fy;
		longint col;
		longint row;
		longint addr;
		if (dw == 0 || dh == 0 || sw == 0 || sh == 0)
			return -1;
		off_x = longint'(r.pixel_x) - longint'(left_x);
		off_y = longint'(r.pixel_y) - longint'(top_y);
		if (off_x < 0 || off_x >= dw || longint'(r.pixel_x) >= surf_w)
			return -1;
		if (off_y < 0 || off_y >= dh || longint'(r.pixel_y) >= surf_h)
			return -1;
		fx = off_x * ((longint'(sw) << FRAC_BITS) / longint'(dw));
		fy = off_y * ((longint'(sh) << FRAC_BITS) / longint'(dh));
		col = (fx >= (longint'(sw) << FRAC_BITS)) ? longint'(sw) - 1 : fx >> FRAC_BITS;
		row = (fy >= (longint'(sh) << FRAC_BITS)) ? longint'(sh) - 1 : fy >> FRAC_BITS;
		addr = row * longint'(sw) + col;
		if (addr >= SPRITE_DEPTH)
			return -1;
		return int'(addr);
	endfunction

	function automatic int pick_size(input int typical);
		case ($urandom_range(0, 9))
			0: return 0;
			1: return int'($urandom_range(0, 8191));
			2: return 4096;
			default: return int'($urandom_range(1, typical));
		endcase
	endfunction

	// One request: random gap, then hold valid until the block takes it.
	task automatic send_request(input blit_req_t r);
		while (!calm && $urandom_range(0, 99) < 29) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data <= r;
		do @(posedge clk); while (!req_ready);
		if (r.action == ACT_LOAD && r.texel_index < SPRITE_DEPTH)
			loaded[r.texel_index] = 1'b1;
	endtask

	// Setup then access phase; psel stays up between back-to-back writes.
	task automatic write_reg(input reg_idx_t idx, input int value);
		logic [PDATA_W-1:0] word;
		word = ($urandom_range(0, 3) == 0) ? $urandom : '0;  // upper bits are don't-care
		word[REG_W-1:0] = REG_W'(value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		penable <= 1'b0;
	endtask

	// Registers only change once every result is back; each request gives one result,
	// so nothing is left in flight after that.
	task automatic set_blit(input int left_x, input int top_y, input int dw, input int dh,
			input int sw, input int sh, input int surf_w, input int surf_h);
		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		write_reg(REG_DEST_LEFT, left_x);
		write_reg(REG_DEST_TOP, top_y);
		write_reg(REG_DEST_WIDTH, dw);
		write_reg(REG_DEST_HEIGHT, dh);
		write_reg(REG_SPRITE_WIDTH, sw);
		write_reg(REG_SPRITE_HEIGHT, sh);
		write_reg(REG_SURFACE_WIDTH, surf_w);
		write_reg(REG_SURFACE_HEIGHT, surf_h);
		psel <= 1'b0;
	endtask

	// Load every texel the current sprite can sample that has not been written yet.
	task automatic fill_sprite(input int count);
		for (int i = 0; i < count && i < SPRITE_DEPTH; i++)
			if (!loaded[i])
				send_request(texel_load(i));
	endtask

	initial begin : stimulus
		blit_req_t r;
		int        left_x;
		int        top_y;
		int        dw;
		int        dh;
		int        sw;
		int        sh;
		int        surf_w;
		int        surf_h;
		int        region;
		int        texel;
		int        xs [4];

		xs = '{0, 2, 4, 5};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: all sizes zero, a pixel at the far corner writes nothing.
		r = '1;
		send_request(r);

		// Directed texels: opaque, transparent, nearly transparent, nearly opaque,
		// white and black, plus the top store index.
		for (int i = 0; i < 16; i++) begin
			r = texel_load((i == 15) ? SPRITE_DEPTH - 1 : i);
			case (i % 4)
				0: r.texel_alpha = 8'hFF;
				1: r.texel_alpha = 8'h00;
				2: r.texel_alpha = 8'h01;
				default: r.texel_alpha = 8'hFE;
			endcase
			{r.texel_red, r.texel_green, r.texel_blue} = (i < 8) ? '1 : '0;
			send_request(r);
		end

		// 4x4 sprite upscaled to 8x8 at a negative origin, clipped by a 5 wide surface:
		// inside, last row/column and clipped by the surface.
		set_blit(-2, -1, 8, 8, 4, 4, 5, 4096);
		fill_sprite(16);
		foreach (xs[k]) begin
			for (int y = 0; y < 8; y += 6) begin
				r = random_bits();
				r.action = ACT_PIXEL;
				r.pixel_x = COORD_BITS'(xs[k]);
				r.pixel_y = COORD_BITS'(y);
				r.dest_color = k[0] ? '1 : '0;
				send_request(r);
			end
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			case (ph)
				// full-size sprite 1:1, rows past the first sample beyond the store
				0: begin
					left_x = 0; top_y = 0; dw = 4096; dh = 4096;
					sw = 4096; sh = 4096; surf_w = 4096; surf_h = 4096;
				end
				// most negative origin with an oversize destination
				1: begin
					left_x = -4096; top_y = -4096; dw = 8191; dh = 8191;
					sw = 16; sh = 16; surf_w = 4096; surf_h = 4096;
				end
				// single pixel at the far corner
				2: begin
					left_x = 4095; top_y = 4095; dw = 1; dh = 1;
					sw = 1; sh = 1; surf_w = 4096; surf_h = 4096;
				end
				// empty surface clips everything
				3: begin
					left_x = 0; top_y = 0; dw = 10; dh = 10;
					sw = 3; sh = 3; surf_w = 0; surf_h = 0;
				end
				default: begin
					left_x = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 8191)) - 4096
						: int'($urandom_range(0, 60)) - 20;
					top_y = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, 8191)) - 4096
						: int'($urandom_range(0, 60)) - 20;
					dw = pick_size(48);
					dh = pick_size(48);
					sw = pick_size(16);
					sh = pick_size(16);
					surf_w = ($urandom_range(0, 2) == 0) ? 4096 : int'($urandom_range(0, 64));
					surf_h = ($urandom_range(0, 2) == 0) ? 4096 : int'($urandom_range(0, 64));
				end
			endcase
			set_blit(left_x, top_y, dw, dh, sw, sh, surf_w, surf_h);
			region = (sw * sh < SPRITE_DEPTH) ? sw * sh : SPRITE_DEPTH;

			calm <= (ph == 6);
			// back the result side up while requests keep coming
			if (ph == 4 || ph == 10)
				hold_asked <= hold_asked + 1;

			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 4) == 0) begin
					// reloads mostly land inside the sprite, overwriting texels in use
					if (region > 0 && $urandom_range(0, 3) != 0)
						send_request(texel_load(int'($urandom_range(0, region - 1))));
					else
						send_request(texel_load(int'($urandom_range(0, SPRITE_DEPTH - 1))));
				end else begin
					r = pixel_near(left_x, top_y, dw, dh);
					texel = sampled_texel(r, left_x, top_y, dw, dh, sw, sh, surf_w, surf_h);
					// a texel is loaded just before the first pixel that samples it
					if (texel >= 0 && !loaded[texel])
						send_request(texel_load(texel));
					send_request(r);
				end
			end
		end

		req_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

### files.f
hw/rtl/sab_pkg.sv
hw/rtl/sab_stepdiv.sv
hw/rtl/sab_front.sv
hw/rtl/sab_queue.sv
hw/rtl/sab_back.sv
hw/rtl/scaled_alpha_sprite_blitter_top.sv
tb/sab_blit_checker.sv
tb/tb_top.sv
